### hdl/bbse_pkg.sv
package bbse_pkg;

  // Number formats
  localparam int COORD_BITS      = 16;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int PARAM_BITS      = PARAM_FRAC_BITS + 1;
  localparam int PROD_BITS       = 2 * PARAM_BITS;
  localparam int MAC_BITS        = COORD_BITS + PARAM_BITS + 1;

  // Control grid geometry
  localparam int GRID_N     = 4;
  localparam int RC_BITS    = 2;
  localparam int IDX_BITS   = 2 * RC_BITS;
  localparam int GRID_CELLS = GRID_N * GRID_N;
  localparam int ACC_BITS   = COORD_BITS + PARAM_BITS + IDX_BITS;
  localparam int QUOT_BITS  = ACC_BITS - PARAM_FRAC_BITS;

  localparam logic [IDX_BITS-1:0]   IDX_LAST = IDX_BITS'(GRID_CELLS - 1);
  localparam logic [PARAM_BITS-1:0] ONE_P    = {1'b1, {PARAM_FRAC_BITS{1'b0}}};
  localparam logic [PARAM_BITS-1:0] HALF_P   = {2'b01, {(PARAM_FRAC_BITS - 1){1'b0}}};

  // Microprogram counter
  localparam int UPC_BITS = 4;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  // Multiplier operand sources of one Bernstein lane
  typedef enum logic [2:0] {
    SRC_T  = 3'd0,
    SRC_S  = 3'd1,
    SRC_S2 = 3'd2,
    SRC_T2 = 3'd3,
    SRC_TS = 3'd4
  } src_e;

  // Destination of the rounded product
  typedef enum logic [3:0] {
    DST_NONE = 4'd0,
    DST_S2   = 4'd1,
    DST_T2   = 4'd2,
    DST_TS   = 4'd3,
    DST_B0   = 4'd4,
    DST_B1   = 4'd5,
    DST_B2   = 4'd6,
    DST_B3   = 4'd7,
    DST_W    = 4'd8
  } dst_e;

  typedef logic [COORD_BITS-1:0]        coord_t;
  typedef logic [2:0][COORD_BITS-1:0]   point_t;

  // One microcode word
  typedef struct packed {
    src_e a_sel;
    src_e b_sel;
    dst_e dst;
    logic triple;   // scale the rounded product by the middle binomial 3
    logic acc_clr;  // clear the coordinate accumulators
    logic loop;     // grid step: repeat over every control point
    logic done;     // hand the result over, then go idle
  } ctrl_t;

  // Sequencer to datapath
  typedef struct packed {
    ctrl_t                word;
    logic [IDX_BITS-1:0]  idx;
    logic                 emit;
  } step_t;

  localparam ctrl_t CTRL_NOP = '{SRC_T, SRC_T, DST_NONE, 1'b0, 1'b0, 1'b0, 1'b0};

  // Control store
  function automatic ctrl_t ucode_f(input logic [UPC_BITS-1:0] upc);
    ctrl_t w;
    w = CTRL_NOP;
    case (upc)
      4'd0: begin w.a_sel = SRC_S;  w.b_sel = SRC_S; w.dst = DST_S2; end
      4'd1: begin w.a_sel = SRC_T;  w.b_sel = SRC_T; w.dst = DST_T2; end
      4'd2: begin w.a_sel = SRC_T;  w.b_sel = SRC_S; w.dst = DST_TS; end
      4'd3: begin w.a_sel = SRC_S2; w.b_sel = SRC_S; w.dst = DST_B0; end
      4'd4: begin
        w.a_sel = SRC_TS; w.b_sel = SRC_S; w.dst = DST_B1; w.triple = 1'b1;
      end
      4'd5: begin
        w.a_sel = SRC_TS; w.b_sel = SRC_T; w.dst = DST_B2; w.triple = 1'b1;
      end
      4'd6: begin
        w.a_sel = SRC_T2; w.b_sel = SRC_T; w.dst = DST_B3; w.acc_clr = 1'b1;
      end
      4'd7: begin w.dst = DST_W; w.loop = 1'b1; end
      4'd8: begin w.dst = DST_NONE; end
      default: begin w.done = 1'b1; end
    endcase
    return w;
  endfunction

  // Round a Q0.F by Q0.F product back to Q0.F, half up
  function automatic logic [PARAM_BITS-1:0] rnd_f(input logic [PROD_BITS-1:0] p);
    logic [PROD_BITS:0] sum;
    sum = {1'b0, p} + {{(PROD_BITS + 1 - PARAM_BITS){1'b0}}, HALF_P};
    return sum[PARAM_FRAC_BITS +: PARAM_BITS];
  endfunction

endpackage

### hdl/bbse_seq.sv
module bbse_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            out_free_i,
  output logic            busy_o,
  output bbse_pkg::step_t step_o
);
  import bbse_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_e;

  seq_state_e            state_q, state_d;
  logic [UPC_BITS-1:0]   upc_q, upc_d;
  logic [IDX_BITS-1:0]   idx_q, idx_d;
  ctrl_t                 word;

  // Fetch the current control word
  always_comb begin
    word = (state_q == ST_RUN) ? ucode_f(upc_q) : CTRL_NOP;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign step_o.word = word;
  assign step_o.idx  = idx_q;
  assign step_o.emit = word.done & out_free_i;

  // Advance, loop over the grid, or hold at the final step
  always_comb begin
    state_d = state_q;
    upc_d   = upc_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RUN;
          upc_d   = '0;
          idx_d   = '0;
        end
      end
      ST_RUN: begin
        if (word.loop) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == IDX_LAST) begin
            upc_d = upc_q + 1'b1;
          end
        end else if (word.done) begin
          if (out_free_i) begin
            state_d = ST_IDLE;
          end
        end else begin
          upc_d = upc_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      upc_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      upc_q   <= upc_d;
      idx_q   <= idx_d;
    end
  end

endmodule

### hdl/bbse_weight.sv
module bbse_weight (
  input  logic                             clk_i,
  input  logic                             load_i,
  input  logic [bbse_pkg::PARAM_BITS-1:0]  u_i,
  input  logic [bbse_pkg::PARAM_BITS-1:0]  v_i,
  input  bbse_pkg::step_t                  step_i,
  output logic [bbse_pkg::PARAM_BITS-1:0]  w_o
);
  import bbse_pkg::*;

  // Lane 0 works on u, lane 1 on v
  logic [PARAM_BITS-1:0] t_q  [2];
  logic [PARAM_BITS-1:0] s_q  [2];
  logic [PARAM_BITS-1:0] s2_q [2];
  logic [PARAM_BITS-1:0] t2_q [2];
  logic [PARAM_BITS-1:0] ts_q [2];
  logic [PARAM_BITS-1:0] b_q  [2][GRID_N];
  logic [PARAM_BITS-1:0] w_q;

  logic [PARAM_BITS-1:0] par   [2];
  logic [PARAM_BITS-1:0] tc    [2];
  logic [PARAM_BITS-1:0] op_a  [2];
  logic [PARAM_BITS-1:0] op_b  [2];
  logic [PROD_BITS-1:0]  prod  [2];
  logic [PARAM_BITS-1:0] rnd_v [2];
  logic [PARAM_BITS+1:0] trip  [2];
  logic [PARAM_BITS-1:0] res   [2];
  logic [RC_BITS-1:0]    ri, ci;

  function automatic logic [PARAM_BITS-1:0] pick(
    input src_e                  sel,
    input logic [PARAM_BITS-1:0] t,
    input logic [PARAM_BITS-1:0] s,
    input logic [PARAM_BITS-1:0] s2,
    input logic [PARAM_BITS-1:0] t2,
    input logic [PARAM_BITS-1:0] ts
  );
    logic [PARAM_BITS-1:0] r;
    case (sel)
      SRC_T:   r = t;
      SRC_S:   r = s;
      SRC_S2:  r = s2;
      SRC_T2:  r = t2;
      SRC_TS:  r = ts;
      default: r = t;
    endcase
    return r;
  endfunction

  assign par[0] = u_i;
  assign par[1] = v_i;
  assign ri     = step_i.idx[IDX_BITS-1 -: RC_BITS];
  assign ci     = step_i.idx[RC_BITS-1:0];
  assign w_o    = w_q;

  // Clamp the parameter to one, select operands, multiply and round
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      tc[l]   = (par[l] > ONE_P) ? ONE_P : par[l];
      op_a[l] = pick(step_i.word.a_sel, t_q[l], s_q[l], s2_q[l], t2_q[l], ts_q[l]);
      op_b[l] = pick(step_i.word.b_sel, t_q[l], s_q[l], s2_q[l], t2_q[l], ts_q[l]);
      if (l == 0 && step_i.word.dst == DST_W) begin
        op_a[l] = b_q[0][ri];
        op_b[l] = b_q[1][ci];
      end
      prod[l]  = op_a[l] * op_b[l];
      rnd_v[l] = rnd_f(prod[l]);
      trip[l]  = {2'b00, rnd_v[l]} + {1'b0, rnd_v[l], 1'b0};
      res[l]   = step_i.word.triple ? trip[l][PARAM_BITS-1:0] : rnd_v[l];
    end
  end

  // Capture parameters on request, write back products per control word
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      if (load_i) begin
        t_q[l] <= tc[l];
        s_q[l] <= ONE_P - tc[l];
      end
      case (step_i.word.dst)
        DST_S2:  s2_q[l]    <= res[l];
        DST_T2:  t2_q[l]    <= res[l];
        DST_TS:  ts_q[l]    <= res[l];
        DST_B0:  b_q[l][0]  <= res[l];
        DST_B1:  b_q[l][1]  <= res[l];
        DST_B2:  b_q[l][2]  <= res[l];
        DST_B3:  b_q[l][3]  <= res[l];
        default: ;
      endcase
    end
    if (step_i.word.dst == DST_W) begin
      w_q <= res[0];
    end
  end

endmodule

### hdl/bbse_mac.sv
module bbse_mac (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_i,
  input  logic [bbse_pkg::IDX_BITS-1:0]   wr_idx_i,
  input  bbse_pkg::point_t                wr_pt_i,
  input  bbse_pkg::step_t                 step_i,
  input  logic [bbse_pkg::PARAM_BITS-1:0] w_i,
  output bbse_pkg::point_t                res_o
);
  import bbse_pkg::*;

  point_t                      grid_q [GRID_CELLS];
  point_t                      p_q;
  logic                        pend_q;
  logic signed [ACC_BITS-1:0]  acc_q  [3];
  logic signed [MAC_BITS-1:0]  prod   [3];
  logic signed [ACC_BITS-1:0]  biased [3];
  logic [QUOT_BITS-1:0]        quot   [3];
  logic [QUOT_BITS-COORD_BITS:0] hi   [3];

  // Store control points, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GRID_CELLS; i++) begin
        grid_q[i] <= '0;
      end
    end else if (wr_i) begin
      grid_q[wr_idx_i] <= wr_pt_i;
    end
  end

  // Mark a fetched point whose weight is ready next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= step_i.word.loop;
    end
  end

  // Fetch the point and accumulate weighted coordinates
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = $signed(p_q[c]) * $signed({1'b0, w_i});
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.word.loop) begin
      p_q <= grid_q[step_i.idx];
    end
    for (int c = 0; c < 3; c++) begin
      if (step_i.word.acc_clr) begin
        acc_q[c] <= '0;
      end else if (pend_q) begin
        acc_q[c] <= acc_q[c] + ACC_BITS'(prod[c]);
      end
    end
  end

  // Round half up, then saturate to the coordinate range
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      biased[c] = acc_q[c] + $signed({{(ACC_BITS - PARAM_BITS){1'b0}}, HALF_P});
      quot[c]   = biased[c][ACC_BITS-1:PARAM_FRAC_BITS];
      hi[c]     = quot[c][QUOT_BITS-1:COORD_BITS-1];
      if ((&hi[c]) || !(|hi[c])) begin
        res_o[c] = quot[c][COORD_BITS-1:0];
      end else if (quot[c][QUOT_BITS-1]) begin
        res_o[c] = {1'b1, {(COORD_BITS - 1){1'b0}}};
      end else begin
        res_o[c] = {1'b0, {(COORD_BITS - 1){1'b1}}};
      end
    end
  end

endmodule

### hdl/bicubic_bezier_surface_eval.sv
// Bicubic Bezier surface point evaluator over a 4x4 grid of Q8.8 control points.
// Input channel (in_valid_i / in_stall_o) carries one request per accepted beat:
//   op_i = load writes px_i, py_i, pz_i at row_i, col_i, no result;
//   op_i = eval takes u_param_i, v_param_i (Q0.16, 1.0 = 65536, larger clamps).
// Output channel (out_valid_o / out_stall_i) returns sx_o, sy_o, sz_o, rounded
// and saturated Q8.8, for each evaluate request, in order.
// An evaluate runs a 25-step microprogram: 7 steps build the cubic Bernstein
// weights in u and v on two lane multipliers, 16 steps walk the control points
// through one product-weight multiplier and three multiply-accumulates, then a
// drain and a write-back step. The result is registered from the write-back step,
// and in_stall_o stays high until that step completes, so a new request waits for
// the grid walk through the single weight multiplier. Loads are taken only while idle.
// While the output register still holds an untaken result, the final step waits
// and in_stall_o stays high. Reset clears the grid to zero and empties the
// output register.
module bicubic_bezier_surface_eval (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   op_i,
  input  logic [bbse_pkg::RC_BITS-1:0]           row_i,
  input  logic [bbse_pkg::RC_BITS-1:0]           col_i,
  input  logic signed [bbse_pkg::COORD_BITS-1:0] px_i,
  input  logic signed [bbse_pkg::COORD_BITS-1:0] py_i,
  input  logic signed [bbse_pkg::COORD_BITS-1:0] pz_i,
  input  logic [bbse_pkg::PARAM_BITS-1:0]        u_param_i,
  input  logic [bbse_pkg::PARAM_BITS-1:0]        v_param_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [bbse_pkg::COORD_BITS-1:0] sx_o,
  output logic signed [bbse_pkg::COORD_BITS-1:0] sy_o,
  output logic signed [bbse_pkg::COORD_BITS-1:0] sz_o
);
  import bbse_pkg::*;

  logic                  in_acc;
  logic                  load_req;
  logic                  eval_req;
  logic                  busy;
  logic                  out_free;
  step_t                 step;
  logic [PARAM_BITS-1:0] weight;
  point_t                res;
  logic                  out_valid_q;
  coord_t                sx_q, sy_q, sz_q;

  assign in_acc     = in_valid_i & ~in_stall_o;
  assign load_req   = in_acc & (op_i == OP_LOAD);
  assign eval_req   = in_acc & (op_i == OP_EVAL);
  assign in_stall_o = busy;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  bbse_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (eval_req),
    .out_free_i (out_free),
    .busy_o     (busy),
    .step_o     (step)
  );

  bbse_weight u_weight (
    .clk_i  (clk_i),
    .load_i (eval_req),
    .u_i    (u_param_i),
    .v_i    (v_param_i),
    .step_i (step),
    .w_o    (weight)
  );

  bbse_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (load_req),
    .wr_idx_i ({row_i, col_i}),
    .wr_pt_i  ({pz_i, py_i, px_i}),
    .step_i   (step),
    .w_i      (weight),
    .res_o    (res)
  );

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step.emit) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.emit) begin
      sx_q <= res[0];
      sy_q <= res[1];
      sz_q <= res[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign sx_o        = sx_q;
  assign sy_o        = sy_q;
  assign sz_o        = sz_q;

`ifndef SYNTHESIS
  a_eval_starts_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_req |=> in_stall_o)
    else $error("evaluate request did not start the sequencer");

  a_result_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step.emit))
    else $error("result appeared without a write-back step");

  a_final_step_waits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step.word.done && !out_free) |=> step.word.done)
    else $error("final step left while the output register was full");
`endif

endmodule
